/* hw/rtl/sld_pkg.sv */
// ----------------------------------------------------------------------------
// sld_pkg
// Shared types and codes for the sync/length deframer.
// ----------------------------------------------------------------------------
package sld_pkg;

  // framing phase
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_PAY  = 2'd2
  } phase_t;

  // byte kind codes on the result word
  localparam logic [1:0] KIND_SYNC = 2'd0;
  localparam logic [1:0] KIND_LEN  = 2'd1;
  localparam logic [1:0] KIND_PAY  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_SYNC_PATTERN = 2'd0;
  localparam logic [1:0] REG_SYNC_COUNT   = 2'd1;
  localparam logic [1:0] REG_LEN_FOUR     = 2'd2;
  localparam logic [1:0] REG_LEN_BIG      = 2'd3;

  localparam logic [2:0] LEN_BYTES_SHORT = 3'd2;
  localparam logic [2:0] LEN_BYTES_LONG  = 3'd4;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [1:0]  byte_kind;
    logic        frame_last;
    logic        length_error;
    logic [30:0] decoded_length;
  } out_word_t;

  typedef struct packed {
    logic [63:0] sync_pattern;
    logic [3:0]  sync_byte_count;
    logic        length_is_four_bytes;
    logic        length_big_endian;
  } cfg_t;

  typedef struct packed {
    logic      valid;
    out_word_t word;
  } res_t;

endpackage

/* hw/rtl/sld_stream_if.sv */
// ----------------------------------------------------------------------------
// sld_stream_if
// Valid/ready stream channel carrying one payload word.
// ----------------------------------------------------------------------------
interface sld_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/sld_cfg_if.sv */
// ----------------------------------------------------------------------------
// sld_cfg_if
// Register write channel: index and write data under valid/ready.
// ----------------------------------------------------------------------------
interface sld_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

/* hw/rtl/sld_cfg_regs.sv */
// ----------------------------------------------------------------------------
// sld_cfg_regs
// Configuration register file for the deframer.
// ----------------------------------------------------------------------------
module sld_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [1:0]    wr_index,
  input  logic [63:0]   wr_data,
  output sld_pkg::cfg_t cfg
);

  sld_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_pattern         <= 64'd0;
      cfg_r.sync_byte_count      <= 4'd1;
      cfg_r.length_is_four_bytes <= 1'b0;
      cfg_r.length_big_endian    <= 1'b1;
    end else if (wr_en) begin
      case (wr_index)
        sld_pkg::REG_SYNC_PATTERN: cfg_r.sync_pattern         <= wr_data;
        sld_pkg::REG_SYNC_COUNT:   cfg_r.sync_byte_count      <= wr_data[3:0];
        sld_pkg::REG_LEN_FOUR:     cfg_r.length_is_four_bytes <= wr_data[0];
        sld_pkg::REG_LEN_BIG:      cfg_r.length_big_endian    <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* hw/rtl/sld_engine.sv */
// ----------------------------------------------------------------------------
// sld_engine
// Framing state and the per-byte step: sync hunt, length gather, payload.
// ----------------------------------------------------------------------------
module sld_engine #(
  parameter int MAX_SYNC_BYTES = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  sld_pkg::cfg_t cfg,
  input  logic          adv,
  input  logic [7:0]    rx_byte,
  output sld_pkg::res_t res
);

  localparam int MW = $clog2(MAX_SYNC_BYTES + 1);
  localparam logic [3:0] MAX_CNT = 4'(MAX_SYNC_BYTES);

  sld_pkg::phase_t phase_r, phase_nxt;
  logic [MW-1:0]   matched_r, matched_nxt;
  logic [2:0]      seen_r, seen_nxt;
  logic [31:0]     gather_r, gather_nxt;
  logic [30:0]     left_r, left_nxt;

  logic [3:0]  cnt;
  logic [3:0]  matched_ext;
  logic [3:0]  m_new;
  logic [2:0]  pos;
  logic [63:0] pat_sh;
  logic [7:0]  want;
  logic        hit, hit0;
  logic        do_len;
  logic [2:0]  seen_e;
  logic [31:0] gather_e;
  logic [1:0]  seen2;
  logic [2:0]  seen_new;
  logic [2:0]  need;
  logic [31:0] g;
  logic [30:0] left_dec;

  always_comb begin
    cnt         = (cfg.sync_byte_count > MAX_CNT) ? MAX_CNT : cfg.sync_byte_count;
    matched_ext = 4'(matched_r);
    pos         = matched_ext[2:0];
    pat_sh      = cfg.sync_pattern >> {pos, 3'b000};
    want        = pat_sh[7:0];
    hit         = (rx_byte == want);
    hit0        = (rx_byte == cfg.sync_pattern[7:0]);
    m_new       = (hit ? matched_ext : 4'd0) + 4'd1;
    left_dec    = (left_r != 31'd0) ? (left_r - 31'd1) : 31'd0;
    need        = cfg.length_is_four_bytes ? sld_pkg::LEN_BYTES_LONG
                                           : sld_pkg::LEN_BYTES_SHORT;

    phase_nxt   = phase_r;
    matched_nxt = matched_r;
    seen_nxt    = seen_r;
    gather_nxt  = gather_r;
    left_nxt    = left_r;
    do_len      = 1'b0;
    seen_e      = seen_r;
    gather_e    = gather_r;

    res.valid                    = 1'b0;
    res.word.data_byte           = rx_byte;
    res.word.byte_kind           = sld_pkg::KIND_SYNC;
    res.word.frame_last          = 1'b0;
    res.word.length_error        = 1'b0;
    res.word.decoded_length      = 31'd0;

    case (phase_r)
      sld_pkg::PH_PAY: begin
        res.valid           = 1'b1;
        res.word.byte_kind  = sld_pkg::KIND_PAY;
        res.word.frame_last = (left_dec == 31'd0);
        left_nxt            = left_dec;
        if (left_dec == 31'd0) begin
          phase_nxt   = sld_pkg::PH_HUNT;
          matched_nxt = '0;
          seen_nxt    = 3'd0;
          gather_nxt  = 32'd0;
        end
      end
      sld_pkg::PH_LEN: begin
        do_len = 1'b1;
      end
      default: begin
        // hunting; an unused phase code behaves the same
        phase_nxt = sld_pkg::PH_HUNT;
        if (matched_ext < cnt) begin
          if (hit || hit0) begin
            // a mismatch that still matches byte 0 restarts the match
            res.valid   = 1'b1;
            matched_nxt = MW'(m_new);
            if (m_new >= cnt) begin
              phase_nxt  = sld_pkg::PH_LEN;
              seen_nxt   = 3'd0;
              gather_nxt = 32'd0;
            end
          end else begin
            matched_nxt = '0;
          end
        end else begin
          // sync word complete (or none): this byte opens the length field
          do_len   = 1'b1;
          seen_e   = 3'd0;
          gather_e = 32'd0;
        end
      end
    endcase

    seen2    = seen_e[1:0];
    seen_new = 3'(seen2) + 3'd1;
    if (cfg.length_big_endian) begin
      g = {gather_e[23:0], rx_byte};
    end else begin
      g = gather_e | (32'(rx_byte) << {seen2, 3'b000});
    end

    if (do_len) begin
      res.valid          = 1'b1;
      res.word.byte_kind = sld_pkg::KIND_LEN;
      if (seen_new >= need) begin
        matched_nxt = '0;
        seen_nxt    = 3'd0;
        gather_nxt  = 32'd0;
        if (g == 32'd0 || g[31]) begin
          res.word.length_error = 1'b1;
          phase_nxt             = sld_pkg::PH_HUNT;
          left_nxt              = 31'd0;
        end else begin
          res.word.decoded_length = g[30:0];
          phase_nxt               = sld_pkg::PH_PAY;
          left_nxt                = g[30:0];
        end
      end else begin
        phase_nxt  = sld_pkg::PH_LEN;
        seen_nxt   = seen_new;
        gather_nxt = g;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= sld_pkg::PH_HUNT;
      matched_r <= '0;
      seen_r    <= 3'd0;
      gather_r  <= 32'd0;
      left_r    <= 31'd0;
    end else if (adv) begin
      phase_r   <= phase_nxt;
      matched_r <= matched_nxt;
      seen_r    <= seen_nxt;
      gather_r  <= gather_nxt;
      left_r    <= left_nxt;
    end
  end

endmodule

/* hw/rtl/sync_length_deframer_unit.sv */
// ----------------------------------------------------------------------------
// sync_length_deframer_unit
// Byte-serial deframer: sync word hunt, length field, counted payload.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : one received byte per word (rx_byte), valid/ready.
//   out_if : one result word per framed byte: the byte, its kind (sync,
//            length, payload), frame_last on the final payload byte, and on
//            the last length byte either decoded_length or length_error.
//            Bytes dropped while hunting give no result word.
//   cfg_if : register writes, always ready; write only while the block is
//            idle (all results taken, two cycles after the last input).
// Path: a byte accepted from in_if is held in the input register, passes the
//   engine logic, and is captured in the result register, from which out_if
//   can take it.
// Throughput: one byte per cycle while out_if takes results; the per-byte step
//   is a single pass through the engine logic between the two registers.
// Reset: sync hunt with no bytes matched; registers take their reset values
//   (pattern 0, one sync byte, two-byte big-endian length).
// Stall: a held result word blocks the input register only; in_if.ready
//   drops solely when both the input and result registers are full and
//   out_if.ready is low.
// ----------------------------------------------------------------------------
module sync_length_deframer_unit #(
  parameter int MAX_SYNC_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  sld_stream_if.sink   in_if,
  sld_stream_if.source out_if,
  sld_cfg_if.sink      cfg_if
);

  sld_pkg::cfg_t      cfg;
  sld_pkg::res_t      res;
  sld_pkg::out_word_t out_word_r;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  logic       out_free;
  logic       s1_adv;
  logic       in_acc;

  assign cfg_if.ready = 1'b1;

  sld_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_if.valid),
    .wr_index (cfg_if.index),
    .wr_data  (cfg_if.wdata),
    .cfg      (cfg)
  );

  assign out_free    = !out_valid_r || out_if.ready;
  assign s1_adv      = s1_valid_r && out_free;
  assign in_if.ready = !s1_valid_r || s1_adv;
  assign in_acc      = in_if.valid && in_if.ready;

  sld_engine #(
    .MAX_SYNC_BYTES (MAX_SYNC_BYTES)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .adv     (s1_adv),
    .rx_byte (s1_byte_r),
    .res     (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_if.data.rx_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_adv && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res.valid) begin
      out_word_r <= res.word;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_word_r;

`ifndef NO_ASSERTIONS
  a_last_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.frame_last |-> out_word_r.byte_kind == sld_pkg::KIND_PAY)
    else $error("frame_last on a non-payload word");

  a_err_no_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.length_error |->
      out_word_r.byte_kind == sld_pkg::KIND_LEN && out_word_r.decoded_length == 31'd0)
    else $error("length_error word carries a length or wrong kind");

  a_stall_only_on_back: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> out_valid_r && !out_if.ready && s1_valid_r)
    else $error("input stalled without a stalled result");

  a_payload_after_len: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && res.valid && res.word.decoded_length != 31'd0 |->
      res.word.byte_kind == sld_pkg::KIND_LEN)
    else $error("decoded length on a non-length word");
`endif

endmodule
